[sv/rspe_pkg.sv]
// Package for the Reed-Solomon parity encoder.
// Holds the shared item and control types, state enums, register indexes and GF(256) math.
// No dependencies.
package rspe_pkg;

    localparam int BYTE_W = 8;
    localparam int PARITY_COUNT_W = 6;
    localparam int FIELD_POLY_W = 9;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_PARITY_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIELD_POLY = 1'b1;

    localparam logic [PARITY_COUNT_W-1:0] PARITY_COUNT_RESET = 6'd10;
    localparam logic [FIELD_POLY_W-1:0] FIELD_POLY_RESET = 9'd285;

    localparam logic [BYTE_W-1:0] ALPHA = 8'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } msg_t;

    typedef struct packed {
        logic clear;
        logic busy;
    } enc_ctrl_t;

    typedef enum logic [1:0] {
        GEN_INIT,
        GEN_STEP,
        GEN_IDLE
    } gen_state_t;

    typedef enum logic {
        BK_RUN,
        BK_EMIT
    } back_state_t;

    // Shift-and-add multiply modulo x^8 + low.
    function automatic logic [BYTE_W-1:0] gf_mul(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] low
    );
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] r;
        x = a;
        r = '0;
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (b[k])
            begin
                r = r ^ x;
            end
            if (x[BYTE_W-1])
            begin
                x = {x[BYTE_W-2:0], 1'b0} ^ low;
            end
            else
            begin
                x = {x[BYTE_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

[sv/reed_solomon_parity_encoder.sv]
// Top level of the systematic Reed-Solomon parity encoder over GF(256).
// Depends on rspe_pkg, rspe_queue, rspe_gen and rspe_back.
//
//   channel   | signals                                          | dir
//   ----------+--------------------------------------------------+-----
//   message   | message_valid, message_ready, message_byte/end   | in
//   parity    | parity_valid, parity_ready, parity_byte/end      | out
//   config    | cfg_write, cfg_index, cfg_data                   | in
//
// The division register takes in each message byte; after the byte marked last,
// the parity bytes are shifted out through the output register. Further message
// transfers wait in a two-entry queue meanwhile. After reset and after each register
// write the generator is rebuilt, one factor per cycle, and message_ready stays low.
// A full output register stalls only the parity shift.
module reed_solomon_parity_encoder #(
    parameter int MAX_PARITY = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               message_valid,
    output logic                               message_ready,
    input  logic [rspe_pkg::BYTE_W-1:0]        message_byte,
    input  logic                               message_end,
    output logic                               parity_valid,
    input  logic                               parity_ready,
    output logic [rspe_pkg::BYTE_W-1:0]        parity_byte,
    output logic                               parity_end,
    input  logic                               cfg_write,
    input  logic [rspe_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rspe_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rspe_pkg::*;

    localparam int NW = $clog2(MAX_PARITY + 1);
    localparam int CMPW = (NW > PARITY_COUNT_W) ? NW : PARITY_COUNT_W;

    logic [PARITY_COUNT_W-1:0]          parity_count_reg;
    logic [FIELD_POLY_W-1:0]            field_poly_reg;
    logic [NW-1:0]                      active_n;
    logic [CMPW-1:0]                    count_ext;
    logic [BYTE_W-1:0]                  poly_low;
    logic                               q_full;
    logic                               q_valid;
    logic                               q_pop;
    logic                               push;
    msg_t                               push_item;
    msg_t                               q_item;
    logic                               gen_busy;
    logic [MAX_PARITY-1:0][BYTE_W-1:0]  coef;
    enc_ctrl_t                          ctrl;

    // A parity count of zero acts as one, and counts above the maximum saturate.
    always_comb
    begin
        count_ext = CMPW'(parity_count_reg);
        if (parity_count_reg == '0)
        begin
            active_n = NW'(1);
        end
        else if (count_ext > CMPW'(MAX_PARITY))
        begin
            active_n = NW'(MAX_PARITY);
        end
        else
        begin
            active_n = NW'(parity_count_reg);
        end
    end

    assign poly_low = field_poly_reg[BYTE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_count_reg <= PARITY_COUNT_RESET;
            field_poly_reg <= FIELD_POLY_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PARITY_COUNT: parity_count_reg <= cfg_data[PARITY_COUNT_W-1:0];
                REG_FIELD_POLY:   field_poly_reg <= cfg_data[FIELD_POLY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign message_ready = !q_full && !gen_busy;
    assign push = message_valid && message_ready;
    assign push_item = '{data: message_byte, last: message_end};

    assign ctrl = '{clear: cfg_write, busy: gen_busy};

    rspe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (q_pop),
        .full       (q_full),
        .item_valid (q_valid),
        .item       (q_item)
    );

    rspe_gen #(
        .MAX_PARITY (MAX_PARITY)
    ) u_gen (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (cfg_write),
        .active_n (active_n),
        .poly_low (poly_low),
        .busy     (gen_busy),
        .coef     (coef)
    );

    rspe_back #(
        .MAX_PARITY (MAX_PARITY)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .active_n   (active_n),
        .poly_low   (poly_low),
        .coef       (coef),
        .item_valid (q_valid),
        .item       (q_item),
        .pop        (q_pop),
        .out_valid  (parity_valid),
        .out_ready  (parity_ready),
        .out_byte   (parity_byte),
        .out_end    (parity_end)
    );

endmodule

[sv/rspe_queue.sv]
// Front part of the encoder: a two-entry queue of message transfers.
// Depends on rspe_pkg for the message item type.
module rspe_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rspe_pkg::msg_t push_item,
    input  logic          pop,
    output logic          full,
    output logic          item_valid,
    output rspe_pkg::msg_t item
);
    import rspe_pkg::*;

    msg_t       entry_reg [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;

    assign full = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[sv/rspe_gen.sv]
// Generator polynomial builder: multiplies in one (x + alpha^i) factor per cycle.
// Depends on rspe_pkg for the GF multiply and the builder state enum.
module rspe_gen #(
    parameter int MAX_PARITY = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    restart,
    input  logic [$clog2(MAX_PARITY+1)-1:0]         active_n,
    input  logic [rspe_pkg::BYTE_W-1:0]             poly_low,
    output logic                                    busy,
    output logic [MAX_PARITY-1:0][rspe_pkg::BYTE_W-1:0] coef
);
    import rspe_pkg::*;

    localparam int NW = $clog2(MAX_PARITY + 1);

    gen_state_t                         state_reg;
    gen_state_t                         state_next;
    logic [MAX_PARITY-1:0][BYTE_W-1:0]  coef_reg;
    logic [MAX_PARITY-1:0][BYTE_W-1:0]  coef_next;
    logic [BYTE_W-1:0]                  power_reg;
    logic [BYTE_W-1:0]                  power_next;
    logic [NW-1:0]                      step_reg;
    logic [NW-1:0]                      step_next;
    logic                               last_step;

    assign coef = coef_reg;
    assign last_step = (step_reg == active_n - NW'(1));

    always_comb
    begin
        state_next = state_reg;
        if (restart)
        begin
            state_next = GEN_INIT;
        end
        else
        begin
            unique case (state_reg)
                GEN_INIT: state_next = GEN_STEP;
                GEN_STEP:
                begin
                    if (last_step)
                    begin
                        state_next = GEN_IDLE;
                    end
                end
                GEN_IDLE: state_next = GEN_IDLE;
                default:  state_next = GEN_INIT;
            endcase
        end
    end

    always_comb
    begin
        busy = (state_reg != GEN_IDLE);
    end

    always_comb
    begin
        coef_next = coef_reg;
        power_next = power_reg;
        step_next = step_reg;
        unique case (state_reg)
            GEN_INIT:
            begin
                coef_next = '0;
                coef_next[0] = 8'd1;
                power_next = 8'd1;
                step_next = '0;
            end
            GEN_STEP:
            begin
                coef_next[0] = gf_mul(coef_reg[0], power_reg, poly_low);
                for (int j = 1; j < MAX_PARITY; j++)
                begin
                    coef_next[j] = coef_reg[j-1] ^ gf_mul(coef_reg[j], power_reg, poly_low);
                end
                power_next = gf_mul(power_reg, ALPHA, poly_low);
                step_next = step_reg + NW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= GEN_INIT;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
        power_reg <= power_next;
    end

endmodule

[sv/rspe_back.sv]
// Back part of the encoder: the byte-wide division register and the parity output stage.
// Depends on rspe_pkg for the GF multiply, item and control types and the state enum.
module rspe_back #(
    parameter int MAX_PARITY = 32
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  rspe_pkg::enc_ctrl_t                         ctrl,
    input  logic [$clog2(MAX_PARITY+1)-1:0]             active_n,
    input  logic [rspe_pkg::BYTE_W-1:0]                 poly_low,
    input  logic [MAX_PARITY-1:0][rspe_pkg::BYTE_W-1:0] coef,
    input  logic                                        item_valid,
    input  rspe_pkg::msg_t                              item,
    output logic                                        pop,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [rspe_pkg::BYTE_W-1:0]                 out_byte,
    output logic                                        out_end
);
    import rspe_pkg::*;

    localparam int NW = $clog2(MAX_PARITY + 1);
    localparam int IW = $clog2(MAX_PARITY);

    back_state_t                        state_reg;
    back_state_t                        state_next;
    logic [MAX_PARITY-1:0][BYTE_W-1:0]  rem_reg;
    logic [MAX_PARITY-1:0][BYTE_W-1:0]  rem_next;
    logic [NW-1:0]                      emit_cnt_reg;
    logic [NW-1:0]                      emit_cnt_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [BYTE_W-1:0]                  out_byte_reg;
    logic                               out_end_reg;
    logic [IW-1:0]                      top_idx;
    logic [BYTE_W-1:0]                  top_byte;
    logic [BYTE_W-1:0]                  feedback;
    logic                               slot_free;
    logic                               load;
    logic                               final_emit;

    assign top_idx = IW'(active_n - NW'(1));
    assign top_byte = rem_reg[top_idx];
    assign feedback = item.data ^ top_byte;
    assign slot_free = !out_valid_reg || out_ready;
    assign final_emit = (emit_cnt_reg == active_n - NW'(1));

    assign out_valid = out_valid_reg;
    assign out_byte = out_byte_reg;
    assign out_end = out_end_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_RUN:
            begin
                if (item_valid && !ctrl.busy && item.last)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (slot_free && final_emit)
                begin
                    state_next = BK_RUN;
                end
            end
            default: state_next = BK_RUN;
        endcase
    end

    always_comb
    begin
        pop = 1'b0;
        load = 1'b0;
        unique case (state_reg)
            BK_RUN:  pop = item_valid && !ctrl.busy;
            BK_EMIT: load = slot_free;
            default:
            begin
            end
        endcase
    end

    // Entries at or above the active count stay zero, so only the low part moves.
    always_comb
    begin
        rem_next = rem_reg;
        emit_cnt_next = emit_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (ctrl.clear)
        begin
            rem_next = '0;
        end
        else if (pop)
        begin
            rem_next[0] = gf_mul(feedback, coef[0], poly_low);
            for (int j = 1; j < MAX_PARITY; j++)
            begin
                if (j < int'(active_n))
                begin
                    rem_next[j] = rem_reg[j-1] ^ gf_mul(feedback, coef[j], poly_low);
                end
            end
            emit_cnt_next = '0;
        end
        else if (load)
        begin
            rem_next[0] = '0;
            for (int j = 1; j < MAX_PARITY; j++)
            begin
                if (j < int'(active_n))
                begin
                    rem_next[j] = rem_reg[j-1];
                end
            end
            emit_cnt_next = emit_cnt_reg + NW'(1);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_RUN;
            rem_reg <= '0;
            emit_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg <= rem_next;
            emit_cnt_reg <= emit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= top_byte;
            out_end_reg <= final_emit;
        end
    end

endmodule
